// ===== design/lpht_pkg.sv =====
// Shared constants, types and codes for the linear-probe hash table.
package lpht_pkg;

    localparam int MAX_SLOTS    = 1024;
    localparam int KEY_BITS     = 31;
    localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
    localparam int CNT_BITS     = SLOT_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(KEY_BITS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [CNT_BITS-1:0]  count_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE
    } back_state_t;

    // request after hashing: home slot already known
    typedef struct packed {
        op_t   op;
        key_t  key;
        slot_t home;
    } job_t;

    typedef struct packed {
        logic valid;
        key_t key;
    } ram_word_t;

    typedef struct packed {
        logic      we;
        slot_t     waddr;
        ram_word_t wdata;
        logic      re;
        slot_t     raddr;
    } ram_req_t;

endpackage

// ===== design/lpht_front.sv =====
// Front end: takes requests and computes the home slot by restoring division.
module lpht_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lpht_pkg::op_t    opcode,
    input  lpht_pkg::key_t   key,
    input  lpht_pkg::count_t table_size,
    input  logic             enable,
    output logic             push_valid,
    output lpht_pkg::job_t   push_job,
    input  logic             push_ready
);
    import lpht_pkg::*;

    front_state_t             state_reg, state_next;
    op_t                      op_reg, op_next;
    key_t                     key_reg, key_next;
    key_t                     dividend_reg, dividend_next;
    count_t                   rem_reg, rem_next;
    logic [DIV_CNT_BITS-1:0]  bit_cnt_reg, bit_cnt_next;
    count_t                   trial;

    // rem < table_size <= MAX_SLOTS, so its top bit is always clear
    assign trial = {rem_reg[CNT_BITS-2:0], dividend_reg[KEY_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        bit_cnt_next  = bit_cnt_reg;
        in_ready      = 1'b0;
        push_valid    = 1'b0;
        push_job.op   = op_reg;
        push_job.key  = key_reg;
        push_job.home = rem_reg[SLOT_BITS-1:0];
        case (state_reg)
            F_IDLE:
            begin
                in_ready = enable;
                if (in_valid && enable)
                begin
                    op_next       = opcode;
                    key_next      = key;
                    dividend_next = key;
                    rem_next      = '0;
                    bit_cnt_next  = DIV_CNT_BITS'(KEY_BITS - 1);
                    state_next    = F_DIV;
                end
            end
            F_DIV:
            begin
                if (trial >= table_size)
                begin
                    rem_next = trial - table_size;
                end
                else
                begin
                    rem_next = trial;
                end
                dividend_next = {dividend_reg[KEY_BITS-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lpht_queue.sv =====
// Small FIFO of hashed requests between front and back.
module lpht_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  lpht_pkg::job_t push_job,
    output logic           push_ready,
    output logic           pop_valid,
    output lpht_pkg::job_t pop_job,
    input  logic           pop
);
    import lpht_pkg::*;

    job_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/lpht_ram.sv =====
// Slot memory: one write port, one registered read port, {valid, key} per slot.
module lpht_ram (
    input  logic                clk,
    input  lpht_pkg::ram_req_t  req,
    output lpht_pkg::ram_word_t rdata
);
    import lpht_pkg::*;

    ram_word_t mem [MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ===== design/lpht_back.sv =====
// Back end: clearing sweep, probe sequencer and result register.
module lpht_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  lpht_pkg::job_t      job,
    output logic                job_pop,
    input  lpht_pkg::count_t    table_size,
    input  logic                clear_start,
    output logic                clearing,
    output lpht_pkg::ram_req_t  ram_req,
    input  lpht_pkg::ram_word_t ram_rdata,
    output logic                out_valid,
    input  logic                out_ready,
    output lpht_pkg::slot_t     slot,
    output lpht_pkg::count_t    probe_count,
    output lpht_pkg::status_t   status
);
    import lpht_pkg::*;

    back_state_t state_reg, state_next;
    slot_t       clr_idx_reg, clr_idx_next;
    job_t        job_reg, job_next;
    slot_t       cur_reg, cur_next;
    count_t      cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    slot_t       slot_reg, slot_next;
    count_t      count_out_reg, count_out_next;
    status_t     status_reg, status_next;

    count_t      size_m1;
    count_t      cur_inc;
    count_t      cnt_inc;
    slot_t       nxt;

    assign size_m1 = table_size - count_t'(1);
    assign cur_inc = {1'b0, cur_reg} + count_t'(1);
    assign nxt     = (cur_inc >= table_size) ? '0 : cur_inc[SLOT_BITS-1:0];
    assign cnt_inc = cnt_reg + count_t'(1);

    assign clearing    = (state_reg == B_CLEAR);
    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign probe_count = count_out_reg;
    assign status      = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        slot_reg      <= slot_next;
        count_out_reg <= count_out_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        job_next       = job_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        count_out_next = count_out_reg;
        status_next    = status_reg;
        job_pop        = 1'b0;
        ram_req        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_idx_reg;
                clr_idx_next  = clr_idx_reg + 1'b1;
                if (clr_idx_reg == size_m1[SLOT_BITS-1:0])
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                // result register must be free before a new request starts
                if (job_valid && !out_valid_reg)
                begin
                    job_pop       = 1'b1;
                    job_next      = job;
                    cur_next      = job.home;
                    cnt_next      = '0;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = job.home;
                    state_next    = B_PROBE;
                end
            end
            B_PROBE:
            begin
                // data for cur_reg arrives now; next slot is read speculatively
                ram_req.re    = 1'b1;
                ram_req.raddr = nxt;
                if (!ram_rdata.valid)
                begin
                    slot_next      = cur_reg;
                    count_out_next = cnt_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                    if (job_reg.op == OP_INSERT)
                    begin
                        ram_req.we        = 1'b1;
                        ram_req.waddr     = cur_reg;
                        ram_req.wdata.valid = 1'b1;
                        ram_req.wdata.key = job_reg.key;
                        status_next       = ST_INSERTED;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else if (job_reg.op == OP_SEARCH && ram_rdata.key == job_reg.key)
                begin
                    slot_next      = cur_reg;
                    count_out_next = cnt_inc;
                    status_next    = ST_FOUND;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else if (cnt_inc == table_size)
                begin
                    count_out_next = cnt_inc;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                    if (job_reg.op == OP_INSERT)
                    begin
                        slot_next   = job_reg.home;
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        slot_next   = cur_reg;
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    cur_next = nxt;
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // a size write empties the table
        if (clear_start)
        begin
            clr_idx_next = '0;
            state_next   = B_CLEAR;
        end
    end

endmodule

// ===== design/linear_probe_hash_table_unit.sv =====
// Linear-probe hash table: insert or search a 31-bit key; one result per request.
// The front end hashes a key as key mod table_size with a restoring divider that
// resolves one remainder bit per cycle: a load, 31 divide steps and a hand-off to
// the queue; it takes no new request until the hand-off. A two-entry queue feeds
// the back end, which reads the slot memory once per cycle while probing, and
// examines up to table_size slots per request. The divider sets the rate for
// short probe runs, the single memory read port for long ones. After reset and
// after every table_size write the back end sweeps the first table_size slots
// clearing valid flags (1024 after reset), and in_ready stays low until it is
// done. table_size writes below 2 or above 1024 are clamped; write it only while
// no request is outstanding.
module linear_probe_hash_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lpht_pkg::op_t                opcode,
    input  logic [lpht_pkg::KEY_BITS-1:0] key,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lpht_pkg::SLOT_BITS-1:0] slot,
    output logic [lpht_pkg::CNT_BITS-1:0]  probe_count,
    output lpht_pkg::status_t            status,
    input  logic                         cfg_wr_en,
    input  logic [lpht_pkg::CNT_BITS-1:0]  cfg_wr_data
);
    import lpht_pkg::*;

    count_t    table_size_reg, table_size_next;
    logic      clearing;
    logic      push_valid, push_ready;
    job_t      push_job;
    logic      job_valid, job_pop;
    job_t      job;
    ram_req_t  ram_req;
    ram_word_t ram_rdata;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data < count_t'(2))
            begin
                table_size_next = count_t'(2);
            end
            else if (cfg_wr_data > count_t'(MAX_SLOTS))
            begin
                table_size_next = count_t'(MAX_SLOTS);
            end
            else
            begin
                table_size_next = cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= count_t'(MAX_SLOTS);
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    lpht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .table_size (table_size_reg),
        .enable     (!clearing),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    lpht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (job_valid),
        .pop_job    (job),
        .pop        (job_pop)
    );

    lpht_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    lpht_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .job_pop     (job_pop),
        .table_size  (table_size_reg),
        .clear_start (cfg_wr_en),
        .clearing    (clearing),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot        (slot),
        .probe_count (probe_count),
        .status      (status)
    );

    // no request taken while the memory sweep is running
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !in_ready)
        else $error("request accepted during clearing sweep");

    // a hit always counts the matching slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FOUND) |-> (probe_count != '0))
        else $error("found result with zero probe count");

    // a new result is only loaded into an empty result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop) |-> (!out_valid))
        else $error("request started while result register busy");

endmodule

// ===== tb/sv/linear_probe_hash_table_unit_test.sv =====
// Testbench for the linear-probe hash table with a local table model.
module linear_probe_hash_table_unit_test;
    import lpht_pkg::*;

    localparam longint unsigned KEY_MAX = (64'd1 << KEY_BITS) - 1;
    localparam int unsigned REQS_PER_CHUNK = 50;
    localparam int unsigned LONG_HOLD_CYCLES = 1500;

    typedef struct {
        op_t  op;
        key_t key;
    } request_t;

    typedef struct {
        slot_t   slot;
        count_t  probes;
        status_t status;
    } outcome_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    op_t          opcode = OP_INSERT;
    key_t         key = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    slot_t        slot;
    count_t       probe_count;
    status_t      status;
    logic         cfg_wr_en = 1'b0;
    count_t       cfg_wr_data = '0;

    request_t     outbound_requests[$];
    outcome_t     promised_results[$];

    // table model
    int unsigned  table_slots = MAX_SLOTS;
    bit [KEY_BITS-1:0] slot_key [MAX_SLOTS];
    bit           slot_used [MAX_SLOTS];
    key_t         inserted_keys[$];

    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_stall_pct = 0;
    logic         rx_hold = 1'b0;
    bit           hold_go = 1'b0;
    int unsigned  fail_count = 0;

    linear_probe_hash_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot        (slot),
        .probe_count (probe_count),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic request_t req(op_t op, longint unsigned k);
        request_t r;
        r.op = op;
        r.key = key_t'(k);
        return r;
    endfunction

    function automatic void queue_request(request_t r);
        outbound_requests.insert(outbound_requests.size(), r);
    endfunction

    // Runs one request through the model table, updating it on insert.
    function automatic outcome_t probe_table(op_t op, key_t k);
        outcome_t    r;
        int unsigned home;
        int unsigned s;
        int unsigned n;
        int unsigned last;
        home = k % table_slots;
        s = home;
        n = 0;
        if (op == OP_INSERT)
        begin
            while (n < table_slots && slot_used[s])
            begin
                s = (s + 1 >= table_slots) ? 0 : s + 1;
                n++;
            end
            if (n >= table_slots)
            begin
                r.slot = slot_t'(home);
                r.probes = count_t'(table_slots);
                r.status = ST_FULL;
            end
            else
            begin
                slot_key[s] = k;
                slot_used[s] = 1'b1;
                r.slot = slot_t'(s);
                r.probes = count_t'(n);
                r.status = ST_INSERTED;
            end
            return r;
        end
        last = s;
        while (n < table_slots)
        begin
            if (!slot_used[s])
            begin
                r.slot = slot_t'(s);
                r.probes = count_t'(n);
                r.status = ST_NOT_FOUND;
                return r;
            end
            n++;
            if (slot_key[s] == k)
            begin
                r.slot = slot_t'(s);
                r.probes = count_t'(n);
                r.status = ST_FOUND;
                return r;
            end
            last = s;
            s = (s + 1 >= table_slots) ? 0 : s + 1;
        end
        r.slot = slot_t'(last);
        r.probes = count_t'(n);
        r.status = ST_NOT_FOUND;
        return r;
    endfunction

    // Key whose home slot sits in a small hot set, wrap-around slot included.
    function automatic longint unsigned colliding_key();
        longint unsigned k;
        int unsigned     home;
        home = ($urandom_range(0, 3) == 0) ? table_slots - 1 : $urandom_range(0, 2);
        k = longint'($urandom) & KEY_MAX;
        k = k - (k % table_slots) + home;
        if (k > KEY_MAX)
            k = k - table_slots;
        return k;
    endfunction

    function automatic longint unsigned random_key();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return KEY_MAX;
        return longint'($urandom) & KEY_MAX;
    endfunction

    // Mostly well-formed traffic: inserts into clusters, searches for stored keys.
    function automatic request_t make_request();
        int unsigned     r;
        int unsigned     sel;
        longint unsigned k;
        r = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        if (r < 40)
        begin
            if (sel < 4 || (sel >= 8 && inserted_keys.size() == 0))
                k = random_key();
            else if (sel < 8)
                k = colliding_key();
            else
                k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            inserted_keys.insert(inserted_keys.size(), key_t'(k));
            return req(OP_INSERT, k);
        end
        if (r < 80 && inserted_keys.size() != 0)
            return req(OP_SEARCH, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
        k = (sel < 5) ? random_key() : colliding_key();
        return req(OP_SEARCH, k);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // sampled between edges so a request being picked up is never missed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (outbound_requests.size() != 0 || in_valid || promised_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_table_size(int unsigned size_req);
        int unsigned v;
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count_t'(size_req);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        v = size_req & 32'h7FF;
        if (v < 2)
            v = 2;
        if (v > MAX_SLOTS)
            v = MAX_SLOTS;
        table_slots = v;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        inserted_keys.delete();
    endtask

    task automatic run_phase(int unsigned size_req, int unsigned tx, int unsigned rx,
                             int unsigned chunks, bit squeeze);
        for (int unsigned c = 0; c < chunks; c++)
        begin
            write_table_size(size_req);
            tx_idle_pct <= tx;
            rx_stall_pct <= rx;
            for (int unsigned i = 0; i < REQS_PER_CHUNK; i++)
                queue_request(make_request());
            if (squeeze && c == 0)
                hold_go = 1'b1;
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        request_t next_req;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                promised_results.insert(promised_results.size(), probe_table(opcode, key));
            if (!in_valid || in_ready)
            begin
                if (outbound_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    next_req = outbound_requests.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_req.op;
                    key <= next_req.key;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (promised_results.size() == 0)
                    report_mismatch($sformatf("result with no request outstanding: slot %0d",
                                              slot));
                else
                begin
                    want = promised_results.pop_front();
                    if (slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
                    if (probe_count !== want.probes)
                        report_mismatch($sformatf("probe_count %0d, want %0d",
                                                  probe_count, want.probes));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                end
            end
            out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the block fills and backs up its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset size 1024: empty search, collisions, wrap from the top slot, duplicates
        queue_request(req(OP_SEARCH, 0));
        queue_request(req(OP_INSERT, 0));
        queue_request(req(OP_INSERT, 1024));
        queue_request(req(OP_INSERT, KEY_MAX));
        queue_request(req(OP_INSERT, 1023));
        queue_request(req(OP_SEARCH, 1023));
        queue_request(req(OP_SEARCH, KEY_MAX));
        queue_request(req(OP_SEARCH, 2048));
        queue_request(req(OP_INSERT, 0));
        queue_request(req(OP_SEARCH, 0));

        // size below range clamps to 2: fill, full insert, exhaustive miss
        write_table_size(1);
        queue_request(req(OP_INSERT, 5));
        queue_request(req(OP_INSERT, 7));
        queue_request(req(OP_INSERT, 9));
        queue_request(req(OP_SEARCH, 4));
        queue_request(req(OP_SEARCH, 7));
        queue_request(req(OP_SEARCH, KEY_MAX));

        // size above range clamps to 1024; table must come back empty
        write_table_size(2047);
        queue_request(req(OP_SEARCH, 5));
        queue_request(req(OP_INSERT, KEY_MAX));
        queue_request(req(OP_SEARCH, KEY_MAX));

        run_phase(13, 0, 0, 3, 1'b0);
        run_phase(0, 86, 0, 2, 1'b0);
        run_phase(64, 0, 86, 4, 1'b0);
        run_phase(7, 6, 6, 3, 1'b0);
        run_phase(100, 86, 86, 3, 1'b0);
        run_phase(1025, 0, 0, 2, 1'b0);
        run_phase(31, 0, 0, 3, 1'b1);
        run_phase(1000, 6, 6, 2, 1'b0);
        run_phase(5, 0, 0, 3, 1'b0);

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== linear_probe_hash_table_unit.f =====
design/lpht_pkg.sv
design/lpht_front.sv
design/lpht_queue.sv
design/lpht_ram.sv
design/lpht_back.sv
design/linear_probe_hash_table_unit.sv
tb/sv/linear_probe_hash_table_unit_test.sv
